[rtl/split_block_bloom_filter_assert.svh]
// Assertion macros for the filter modules; the back module uses them.
// Each use names a label, the clock, the reset, an antecedent, a consequent and a message.
`ifndef SPLIT_BLOCK_BLOOM_FILTER_ASSERT_SVH
`define SPLIT_BLOCK_BLOOM_FILTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SBBF_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SBBF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/sbbf_pkg.sv]
`default_nettype none

package sbbf_pkg;

  localparam int WORDS_PER_BLOCK = 8;
  localparam int WORD_W          = 32;
  localparam int POS_W           = 5;
  localparam int BIT_SEL_SHIFT   = 27;
  localparam int MASK_W          = 10;
  localparam int POS_VEC_W       = WORDS_PER_BLOCK * POS_W;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = 2;
  localparam int QUEUE_CNT_W = 3;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_BLK_MASK    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SALT_PAIR_0 = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SALT_PAIR_1 = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SALT_PAIR_2 = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_SALT_PAIR_3 = 3'd4;

  // Operation codes.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef logic [POS_W-1:0] bit_pos_t;
  typedef bit_pos_t [WORDS_PER_BLOCK-1:0] pos_vec_t;
  typedef logic [WORDS_PER_BLOCK-1:0][WORD_W-1:0] block_t;

endpackage

`default_nettype wire

[rtl/sbbf_queue.sv]
`default_nettype none

module sbbf_queue #(
  parameter int DATA_W = 51
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire logic [DATA_W-1:0] push_data,
  output logic                   full,
  input  wire logic              pop,
  output logic      [DATA_W-1:0] pop_data,
  output logic                   empty
);

  localparam int PW = sbbf_pkg::QUEUE_PTR_W;
  localparam int CW = sbbf_pkg::QUEUE_CNT_W;
  localparam int DEPTH = sbbf_pkg::QUEUE_DEPTH;

  logic [DATA_W-1:0] slots [DEPTH];
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     rd_ptr;
  logic [CW-1:0]     count;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop && !empty) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/sbbf_front.sv]
`default_nettype none

module sbbf_front #(
  parameter int BLOCK_COUNT = 1024,
  parameter int IDX_W       = 10
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_write,
  input  wire logic [sbbf_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire logic [sbbf_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  wire logic                                  hold,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic                                  op,
  input  wire logic [63:0]                           hash,
  output logic                                       q_push,
  output logic [1+IDX_W+sbbf_pkg::POS_VEC_W-1:0]     q_data,
  input  wire logic                                  q_full
);

  localparam int MW    = sbbf_pkg::MASK_W;
  localparam int WW    = sbbf_pkg::WORD_W;
  localparam int NW    = sbbf_pkg::WORDS_PER_BLOCK;
  localparam int SPLIT = 5;

  logic [MW-1:0] blk_sel_mask;
  logic [WW-1:0] salt [NW];

  logic          s1_valid;
  logic          s1_op;
  logic [WW-1:0] s1_upper;
  logic [MW-1:0] s1_rem;
  logic [MW-1:0] s1_red;
  logic [WW-1:0] prod [NW];
  sbbf_pkg::pos_vec_t pos_next;

  logic          s2_valid;
  logic          s2_op;
  logic [MW-1:0] s2_rem;
  logic [MW-1:0] s2_red;
  sbbf_pkg::pos_vec_t s2_pos;

  logic accept;
  logic s1_adv;

  assign q_push   = s2_valid && !q_full;
  assign s1_adv   = s1_valid && (!s2_valid || q_push);
  assign in_stall = hold || (s1_valid && !s1_adv);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      blk_sel_mask <= '0;
      for (int w = 0; w < NW; w++) begin
        salt[w] <= '0;
      end
    end else if (cfg_write) begin
      unique case (cfg_index)
        sbbf_pkg::CFG_BLK_MASK: blk_sel_mask <= cfg_data[MW-1:0];
        sbbf_pkg::CFG_SALT_PAIR_0: begin
          salt[0] <= cfg_data[31:0];
          salt[1] <= cfg_data[63:32];
        end
        sbbf_pkg::CFG_SALT_PAIR_1: begin
          salt[2] <= cfg_data[31:0];
          salt[3] <= cfg_data[63:32];
        end
        sbbf_pkg::CFG_SALT_PAIR_2: begin
          salt[4] <= cfg_data[31:0];
          salt[5] <= cfg_data[63:32];
        end
        sbbf_pkg::CFG_SALT_PAIR_3: begin
          salt[6] <= cfg_data[31:0];
          salt[7] <= cfg_data[63:32];
        end
        default: ;
      endcase
    end
  end

  // Upper half of the block reduction and the salt products.
  always_comb begin
    s1_red = s1_rem;
    for (int k = MW - 1; k >= SPLIT; k--) begin
      if (32'(s1_red) >= (32'(BLOCK_COUNT) << k)) begin
        s1_red = s1_red - MW'(32'(BLOCK_COUNT) << k);
      end
    end
    for (int w = 0; w < NW; w++) begin
      prod[w]     = s1_upper * salt[w];
      pos_next[w] = prod[w][WW-1:sbbf_pkg::BIT_SEL_SHIFT];
    end
  end

  // Lower half of the block reduction.
  always_comb begin
    s2_red = s2_rem;
    for (int k = SPLIT - 1; k >= 0; k--) begin
      if (32'(s2_red) >= (32'(BLOCK_COUNT) << k)) begin
        s2_red = s2_red - MW'(32'(BLOCK_COUNT) << k);
      end
    end
  end

  assign q_data = {s2_op, IDX_W'(s2_red), s2_pos};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        s2_valid <= 1'b1;
      end else if (q_push) begin
        s2_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op    <= op;
      s1_upper <= hash[63:32];
      s1_rem   <= hash[MW-1:0] & blk_sel_mask;
    end
    if (s1_adv) begin
      s2_op  <= s1_op;
      s2_rem <= s1_red;
      s2_pos <= pos_next;
    end
  end

endmodule

`default_nettype wire

[rtl/sbbf_back.sv]
`default_nettype none
`include "split_block_bloom_filter_assert.svh"

module sbbf_back #(
  parameter int BLOCK_COUNT = 1024,
  parameter int IDX_W       = 10
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  q_empty,
  input  wire logic [1+IDX_W+sbbf_pkg::POS_VEC_W-1:0] q_data,
  output logic                                       q_pop,
  output logic                                       clearing,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic                                       maybe_present
);

  localparam int PVW = sbbf_pkg::POS_VEC_W;
  localparam int NW  = sbbf_pkg::WORDS_PER_BLOCK;
  localparam int WW  = sbbf_pkg::WORD_W;

  typedef enum logic {
    ST_IDLE,
    ST_CHECK
  } state_t;

  state_t state;

  sbbf_pkg::block_t mem [BLOCK_COUNT];
  sbbf_pkg::block_t rd_data;
  sbbf_pkg::block_t bit_mask;
  sbbf_pkg::block_t wr_data;
  logic [IDX_W-1:0] wr_addr;
  logic             mem_we;

  logic               head_op;
  logic [IDX_W-1:0]   head_idx;
  sbbf_pkg::pos_vec_t head_pos;

  logic               cur_op;
  logic [IDX_W-1:0]   cur_idx;
  sbbf_pkg::pos_vec_t cur_pos;

  logic             clr_active;
  logic [IDX_W-1:0] clr_addr;
  logic             hit;
  logic             resolve;
  logic             ins_check;
  logic             qry_check;

  assign head_op  = q_data[IDX_W+PVW];
  assign head_idx = q_data[PVW +: IDX_W];
  assign head_pos = q_data[PVW-1:0];

  assign clearing = clr_active;
  assign q_pop    = (state == ST_IDLE) && !clr_active && !q_empty;

  always_comb begin
    for (int w = 0; w < NW; w++) begin
      bit_mask[w] = WW'(1) << cur_pos[w];
    end
  end

  assign hit       = ((rd_data & bit_mask) == bit_mask);
  assign ins_check = (state == ST_CHECK) && (cur_op == sbbf_pkg::OP_INSERT);
  assign qry_check = (state == ST_CHECK) && (cur_op == sbbf_pkg::OP_QUERY);
  assign resolve   = (state == ST_CHECK) &&
                     ((cur_op == sbbf_pkg::OP_INSERT) || !out_valid || !out_stall);
  assign mem_we    = clr_active || (resolve && (cur_op == sbbf_pkg::OP_INSERT));
  assign wr_addr   = clr_active ? clr_addr : cur_idx;
  assign wr_data   = clr_active ? '0 : (rd_data | bit_mask);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (q_pop) begin
      rd_data <= mem[head_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      out_valid  <= 1'b0;
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else begin
      if (clr_active) begin
        if (clr_addr == IDX_W'(BLOCK_COUNT - 1)) begin
          clr_active <= 1'b0;
        end
        clr_addr <= clr_addr + IDX_W'(1);
      end
      // A new query result may replace the one taken at this same edge.
      if (resolve && (cur_op == sbbf_pkg::OP_QUERY)) begin
        out_valid     <= 1'b1;
        maybe_present <= hit;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_pop) begin
            cur_op  <= head_op;
            cur_idx <= head_idx;
            cur_pos <= head_pos;
            state   <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (resolve) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `SBBF_ASSERT_IMPLY(a_no_pop_while_clearing, clk, rst, clr_active, !q_pop, "pop during clear")
  `SBBF_ASSERT_IMPLY(a_write_source, clk, rst, mem_we, clr_active || ins_check, "stray write")
  `SBBF_ASSERT_IMPLY(a_result_source, clk, rst, $rose(out_valid), $past(qry_check), "stray result")
  `SBBF_ASSERT_NEXT(a_check_follows_pop, clk, rst, q_pop, state == ST_CHECK, "no check after pop")

endmodule

`default_nettype wire

[rtl/split_block_bloom_filter.sv]
// With the back idle, a query is registered in the front stages, the queue, the block read and
// out_valid. The back finishes the read-modify-write of one block row before it takes the next.
// The front takes a transaction each cycle until the four-entry queue and its stages fill.
// Reset: synchronous, active high; clears control state and the configuration registers.
// After reset a clearing pass zeroes every block row, one row a cycle, and in_stall stays
// high until it ends; configuration writes are taken throughout.
`default_nettype none

module split_block_bloom_filter #(
  parameter int BLOCK_COUNT = 1024
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_write,
  input  wire logic [sbbf_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [sbbf_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              op,
  input  wire logic [63:0]                       hash,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   maybe_present
);

  // Block index width; a single-block store still gets one address bit.
  localparam int IDX_W    = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
  // A queue entry carries the operation, the block index and the eight bit positions.
  localparam int Q_DATA_W = 1 + IDX_W + sbbf_pkg::POS_VEC_W;

  logic                q_push;
  logic [Q_DATA_W-1:0] q_push_data;
  logic                q_full;
  logic                q_pop;
  logic [Q_DATA_W-1:0] q_pop_data;
  logic                q_empty;
  logic                clearing;

  // The front accepts each transaction, masks and wraps the block index, and forms the
  // eight bit positions from the salted products of the upper hash half. It holds the configuration
  // registers. Software must write them only while the filter is quiet; the front does not check.
  sbbf_front #(
    .BLOCK_COUNT (BLOCK_COUNT),
    .IDX_W       (IDX_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .hold      (clearing),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .hash      (hash),
    .q_push    (q_push),
    .q_data    (q_push_data),
    .q_full    (q_full)
  );

  // The queue decouples the front pipeline from the memory side, so a stalled result
  // consumer does not immediately back-pressure the input channel.
  sbbf_queue #(
    .DATA_W (Q_DATA_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .empty     (q_empty)
  );

  // The back owns the block memory. It reads one 256-bit row, then either ORs the eight
  // selected bits back in for an insert or tests them for a query. Only one transaction is
  // in flight there, so back-to-back updates of the same block always see each other.
  sbbf_back #(
    .BLOCK_COUNT (BLOCK_COUNT),
    .IDX_W       (IDX_W)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_data        (q_pop_data),
    .q_pop         (q_pop),
    .clearing      (clearing),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .maybe_present (maybe_present)
  );

endmodule

`default_nettype wire

[tb/split_block_bloom_filter_tb.sv]
module split_block_bloom_filter_tb;
  import sbbf_pkg::*;

  // The block is built at its default size, so the block index never leaves the store.
  localparam int BLOCK_COUNT = 1024;
  localparam int FILTER_DEPTH = BLOCK_COUNT * WORDS_PER_BLOCK;

  // Indexes past the register list. Writes to them must leave every register alone.
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_LO = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_HI = 3'd7;

  // An insert gives no result, so after the last query result up to seven inserts may
  // still sit in the front stages, the queue and the back, which takes them one at a time.
  localparam int SETTLE_CYCLES = 40;
  localparam int TAIL_CYCLES = 20;
  localparam int PHASES = 6;
  localparam int ITEMS_PER_PHASE = 90;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;
  typedef enum logic {CHECK_MODEL, CHECK_FIXED} row_check_t;

  // One line of the directed plan. A configuration line uses index and value; a
  // transaction line uses op and value (the hash), and a fixed line also carries
  // the answer that must come back.
  typedef struct packed {
    row_kind_t kind;
    logic [CFG_INDEX_W-1:0] index;
    logic op;
    logic [63:0] value;
    row_check_t check;
    logic hit;
  } probe_row_t;

  localparam int PLAN_LEN = 27;
  localparam probe_row_t PLAN [0:PLAN_LEN-1] = '{
    // Fresh store with mask and salts at reset: everything lands on bit 0 of block 0.
    '{ROW_ITEM, CFG_BLK_MASK, OP_QUERY,  64'h0000000000000000, CHECK_FIXED, 1'b0},
    '{ROW_ITEM, CFG_BLK_MASK, OP_QUERY,  64'hFFFFFFFFFFFFFFFF, CHECK_FIXED, 1'b0},
    '{ROW_ITEM, CFG_BLK_MASK, OP_INSERT, 64'h0000000000000000, CHECK_MODEL, 1'b0},
    '{ROW_ITEM, CFG_BLK_MASK, OP_QUERY,  64'hFFFFFFFF00000000, CHECK_FIXED, 1'b1},
    // Writes past the register list must not disturb the mask or the salts.
    '{ROW_CFG,  CFG_UNUSED_LO, OP_INSERT, 64'hFFFFFFFFFFFFFFFF, CHECK_MODEL, 1'b0},
    '{ROW_CFG,  CFG_UNUSED_HI, OP_INSERT, 64'hFFFFFFFFFFFFFFFF, CHECK_MODEL, 1'b0},
    '{ROW_ITEM, CFG_BLK_MASK, OP_QUERY,  64'h123456789ABCDEF0, CHECK_FIXED, 1'b1},
    // Widest mask, with every data bit set so that only the low ten bits may count.
    '{ROW_CFG,  CFG_BLK_MASK, OP_INSERT, 64'hFFFFFFFFFFFFFFFF, CHECK_MODEL, 1'b0},
    '{ROW_ITEM, CFG_BLK_MASK, OP_QUERY,  64'h00000000000003FF, CHECK_FIXED, 1'b0},
    '{ROW_ITEM, CFG_BLK_MASK, OP_INSERT, 64'hFFFFFFFFFFFFFFFF, CHECK_MODEL, 1'b0},
    '{ROW_ITEM, CFG_BLK_MASK, OP_QUERY,  64'h00000000000003FF, CHECK_FIXED, 1'b1},
    '{ROW_ITEM, CFG_BLK_MASK, OP_QUERY,  64'h00000000000003FE, CHECK_FIXED, 1'b0},
    // Largest salts.
    '{ROW_CFG,  CFG_SALT_PAIR_0, OP_INSERT, 64'hFFFFFFFFFFFFFFFF, CHECK_MODEL, 1'b0},
    '{ROW_CFG,  CFG_SALT_PAIR_1, OP_INSERT, 64'hFFFFFFFFFFFFFFFF, CHECK_MODEL, 1'b0},
    '{ROW_CFG,  CFG_SALT_PAIR_2, OP_INSERT, 64'hFFFFFFFFFFFFFFFF, CHECK_MODEL, 1'b0},
    '{ROW_CFG,  CFG_SALT_PAIR_3, OP_INSERT, 64'hFFFFFFFFFFFFFFFF, CHECK_MODEL, 1'b0},
    '{ROW_ITEM, CFG_BLK_MASK, OP_INSERT, 64'h8000000000000155, CHECK_MODEL, 1'b0},
    '{ROW_ITEM, CFG_BLK_MASK, OP_QUERY,  64'h8000000000000155, CHECK_FIXED, 1'b1},
    '{ROW_ITEM, CFG_BLK_MASK, OP_QUERY,  64'h0000000100000155, CHECK_MODEL, 1'b0},
    // Distinct odd salts of the usual kind and a small mask.
    '{ROW_CFG,  CFG_SALT_PAIR_0, OP_INSERT, 64'h44974D9147B6137B, CHECK_MODEL, 1'b0},
    '{ROW_CFG,  CFG_SALT_PAIR_1, OP_INSERT, 64'hA2B7289D8824AD5B, CHECK_MODEL, 1'b0},
    '{ROW_CFG,  CFG_SALT_PAIR_2, OP_INSERT, 64'h2DF1424B705495C7, CHECK_MODEL, 1'b0},
    '{ROW_CFG,  CFG_SALT_PAIR_3, OP_INSERT, 64'h5C6BFB319EFC4947, CHECK_MODEL, 1'b0},
    '{ROW_CFG,  CFG_BLK_MASK, OP_INSERT, 64'h0000000000000007, CHECK_MODEL, 1'b0},
    '{ROW_ITEM, CFG_BLK_MASK, OP_INSERT, 64'hDEADBEEF00000003, CHECK_MODEL, 1'b0},
    // Same upper half in the same block, then a neighbor of the upper half.
    '{ROW_ITEM, CFG_BLK_MASK, OP_QUERY,  64'hDEADBEEF0000000B, CHECK_MODEL, 1'b0},
    '{ROW_ITEM, CFG_BLK_MASK, OP_QUERY,  64'hDEADBEEE00000003, CHECK_MODEL, 1'b0}
  };

  logic clk;
  logic rst;
  logic cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic op;
  logic [63:0] hash;
  logic out_valid;
  logic out_stall;
  logic maybe_present;

  split_block_bloom_filter #(
    .BLOCK_COUNT(BLOCK_COUNT)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .op(op),
    .hash(hash),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .maybe_present(maybe_present)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Shadow copy of the filter and its registers, updated as each transaction or
  // register write is taken by the block.
  logic [WORD_W-1:0] filter_mem [0:FILTER_DEPTH-1];
  logic [MASK_W-1:0] mask_cfg = '0;
  logic [WORD_W-1:0] salt_cfg [0:WORDS_PER_BLOCK-1] = '{default: '0};

  // Answers still owed by the block, oldest first.
  logic presence_q [$];
  int mismatch_count = 0;

  // Quiet phases switch off the idling on one side or the other.
  bit quiet_in = 1'b0;
  bit quiet_out = 1'b0;
  int stall_left = 0;
  logic owed_hit;

  // The upper half of the hash times the word's salt, modulo 2^32; the top five bits
  // of the product pick the bit within the word.
  function automatic logic [WORD_W-1:0] word_bit(logic [31:0] upper, int w);
    logic [WORD_W-1:0] prod;
    logic [WORD_W-1:0] pos;
    prod = upper * salt_cfg[w];
    pos = prod >> BIT_SEL_SHIFT;
    return {{(WORD_W-1){1'b0}}, 1'b1} << pos[POS_W-1:0];
  endfunction

  function automatic int block_base(logic [63:0] h);
    logic [63:0] idx;
    idx = h & {{(64-MASK_W){1'b0}}, mask_cfg};
    return int'(idx % BLOCK_COUNT) * WORDS_PER_BLOCK;
  endfunction

  function automatic logic query_hits(logic [63:0] h);
    int base;
    logic all_set;
    base = block_base(h);
    all_set = 1'b1;
    for (int w = 0; w < WORDS_PER_BLOCK; w++) begin
      if ((filter_mem[base + w] & word_bit(h[63:32], w)) != word_bit(h[63:32], w)) begin
        all_set = 1'b0;
      end
    end
    return all_set;
  endfunction

  function automatic void insert_hash(logic [63:0] h);
    int base;
    base = block_base(h);
    for (int w = 0; w < WORDS_PER_BLOCK; w++) begin
      filter_mem[base + w] = filter_mem[base + w] | word_bit(h[63:32], w);
    end
  endfunction

  // Gap length for either side: mostly none or short, now and then long.
  function automatic int gap_len(bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else begin
      return $urandom_range(8, 40);
    end
  endfunction

  // Offers one transaction and waits for the block to take it. The caller sits on a
  // rising edge. With no gap, valid stays high and only the payload moves on.
  task automatic send_request(logic req_op, logic [63:0] req_hash, bit use_fixed,
                              logic fixed_hit);
    int gap;
    gap = gap_len(quiet_in);
    if (gap > 0) begin
      in_valid <= 1'b0;
      op <= 1'($urandom_range(0, 1));
      hash <= {$urandom, $urandom};
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= req_op;
    hash <= req_hash;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (req_op == OP_QUERY) begin
      presence_q.push_back(use_fixed ? fixed_hit : query_hits(req_hash));
    end else begin
      insert_hash(req_hash);
    end
  endtask

  // Lets the block run dry before its registers change: every answer in, then enough
  // cycles for the inserts that may still be on their way to the memory.
  task automatic settle();
    in_valid <= 1'b0;
    while (presence_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    int pair;
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      CFG_BLK_MASK: begin
        mask_cfg = data[MASK_W-1:0];
      end
      CFG_SALT_PAIR_0, CFG_SALT_PAIR_1, CFG_SALT_PAIR_2, CFG_SALT_PAIR_3: begin
        pair = int'(idx - CFG_SALT_PAIR_0);
        salt_cfg[2 * pair] = data[31:0];
        salt_cfg[2 * pair + 1] = data[63:32];
      end
      default: begin
      end
    endcase
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // Result side: check each result against the oldest owed answer, then decide
  // whether to hold off the next one. Stalls come in runs of random length.
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (presence_q.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with no query pending, expected none, actual %0b",
                 $time, maybe_present);
      end else begin
        owed_hit = presence_q.pop_front();
        if (maybe_present !== owed_hit) begin
          mismatch_count++;
          $display("%0t: maybe_present mismatch, expected %0b, actual %0b",
                   $time, owed_hit, maybe_present);
        end
      end
    end
    if (stall_left == 0 && !quiet_out && $urandom_range(0, 3) == 0) begin
      stall_left = gap_len(1'b0);
    end
    out_stall <= (stall_left != 0);
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
    end
  end

  initial begin
    probe_row_t row;
    logic [63:0] h;
    logic [63:0] inserted [$];
    logic [CFG_DATA_W-1:0] salt_word;
    int pick;
    int k;

    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= CFG_BLK_MASK;
    cfg_data <= '0;
    in_valid <= 1'b0;
    op <= OP_INSERT;
    hash <= '0;
    out_stall <= 1'b0;
    for (int i = 0; i < FILTER_DEPTH; i++) begin
      filter_mem[i] = '0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed plan. The block clears the store after reset, and the first transaction
    // simply waits out in_stall.
    for (int i = 0; i < PLAN_LEN; i++) begin
      row = PLAN[i];
      if (row.kind == ROW_CFG) begin
        settle();
        write_register(row.index, row.value);
      end else begin
        send_request(row.op, row.value, row.check == CHECK_FIXED, row.hit);
      end
    end

    // Random phases, each with its own mask; each salt pair is rewritten at random, and every pair in the
    // first phase. Most queries ask for a hash inserted earlier in the phase, some for a near miss
    // with one bit of the upper half flipped, and the rest for anything at all.
    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      quiet_in = ($urandom_range(0, 3) == 0);
      quiet_out = ($urandom_range(0, 3) == 0);
      k = $urandom_range(0, MASK_W);
      if (phase % 3 == 2) begin
        write_register(CFG_BLK_MASK, {$urandom, $urandom});
      end else begin
        write_register(CFG_BLK_MASK, {$urandom, $urandom} & ~((64'd1 << MASK_W) - 1) |
                                     ((64'd1 << k) - 1));
      end
      for (int p = 0; p < 4; p++) begin
        if (phase == 0 || $urandom_range(0, 9) < 7) begin
          pick = $urandom_range(0, 9);
          salt_word = (pick == 0) ? '0 : (pick == 1) ? '1 : {$urandom, $urandom};
          write_register(CFG_INDEX_W'(CFG_SALT_PAIR_0 + p), salt_word);
        end
      end
      if ($urandom_range(0, 3) == 0) begin
        write_register(CFG_INDEX_W'($urandom_range(CFG_UNUSED_LO, CFG_UNUSED_HI)),
                       {$urandom, $urandom});
      end
      inserted.delete();
      repeat (ITEMS_PER_PHASE) begin
        pick = $urandom_range(0, 99);
        if (pick < 40 || inserted.size() == 0) begin
          h = {$urandom, $urandom};
          inserted.push_back(h);
          send_request(OP_INSERT, h, 1'b0, 1'b0);
        end else if (pick < 75) begin
          send_request(OP_QUERY, inserted[$urandom_range(0, inserted.size() - 1)],
                       1'b0, 1'b0);
        end else if (pick < 88) begin
          h = inserted[$urandom_range(0, inserted.size() - 1)];
          h[63:32] = h[63:32] ^ (32'd1 << $urandom_range(0, 31));
          send_request(OP_QUERY, h, 1'b0, 1'b0);
        end else begin
          send_request(OP_QUERY, {$urandom, $urandom}, 1'b0, 1'b0);
        end
      end
    end

    // Everything is in; wait for the owed answers and a short tail for stray results.
    in_valid <= 1'b0;
    while (presence_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // A correct run takes well under a tenth of this, long gaps and stalls included.
  initial begin
    #1000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/sbbf_pkg.sv
rtl/sbbf_queue.sv
rtl/sbbf_front.sv
rtl/sbbf_back.sv
rtl/split_block_bloom_filter.sv
tb/split_block_bloom_filter_tb.sv
